// ===== rtl/i32alu_pkg.sv =====
// Shared types and command codes for the 32-bit expression ALU.
`timescale 1ns / 1ps
package i32alu_pkg;

	localparam int DataW = 32;

	// Command codes
	localparam logic [3:0] CMD_ADD  = 4'd0;
	localparam logic [3:0] CMD_SUB  = 4'd1;
	localparam logic [3:0] CMD_MUL  = 4'd2;
	localparam logic [3:0] CMD_DIV  = 4'd3;
	localparam logic [3:0] CMD_POW  = 4'd4;
	localparam logic [3:0] CMD_NEG  = 4'd5;
	localparam logic [3:0] CMD_ABS  = 4'd6;
	localparam logic [3:0] CMD_PLUS = 4'd7;
	localparam logic [3:0] CMD_EQ   = 4'd8;
	localparam logic [3:0] CMD_NE   = 4'd9;
	localparam logic [3:0] CMD_LT   = 4'd10;
	localparam logic [3:0] CMD_LE   = 4'd11;
	localparam logic [3:0] CMD_GT   = 4'd12;
	localparam logic [3:0] CMD_GE   = 4'd13;

	// Controller to datapath
	typedef struct packed {
		logic load;      // capture operands, set up the operation
		logic step;      // one iteration of divide or power
		logic finish;    // form the result into the output register
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic iter_op;   // operation needs the iterative unit
		logic iter_done; // iterative unit has finished
	} dp_stat_t;

endpackage

// ===== rtl/i32alu_dp.sv =====
// Datapath: operand registers, shared multiplier, shift-subtract divider, power loop.
`timescale 1ns / 1ps
module i32alu_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  i32alu_pkg::dp_cmd_t   cmd,
	output i32alu_pkg::dp_stat_t  stat,
	input  logic [3:0]            in_command,
	input  logic [31:0]           in_a,
	input  logic [31:0]           in_b,
	output logic [31:0]           res_value,
	output logic                  res_status
);
	import i32alu_pkg::*;

	logic [3:0]  op_q;
	logic [31:0] a_q, b_q;
	logic        bad_q;      // div error or pow that yields zero
	logic [5:0]  cnt_q;
	// divider: remainder, quotient, divisor magnitude
	logic [31:0] rem_q, quo_q, dvs_q;
	logic        qneg_q;
	// power: accumulator, base square, exponent
	logic [31:0] acc_q, bas_q, exp_q;
	logic        phase_q;    // power does acc multiply then square on alternate steps

	logic [31:0] abs_a, abs_b;
	logic [32:0] rem_sh, rem_sub;
	logic [31:0] mul_x, mul_y, mul_p;
	logic        is_div, is_pow;

	assign abs_a  = in_a[31] ? (32'd0 - in_a) : in_a;
	assign abs_b  = in_b[31] ? (32'd0 - in_b) : in_b;
	assign is_div = (in_command == CMD_DIV);
	assign is_pow = (in_command == CMD_POW);

	// Shared 32x32 low-half multiplier
	always_comb begin
		mul_x = a_q;
		mul_y = b_q;
		if (op_q == CMD_POW) begin
			mul_x = phase_q ? bas_q : acc_q;
			mul_y = bas_q;
		end
	end
	assign mul_p = mul_x * mul_y;

	// One restoring divide step
	assign rem_sh  = {rem_q, quo_q[31]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	assign stat.iter_op   = (op_q == CMD_DIV || op_q == CMD_POW) && !bad_q;
	assign stat.iter_done = (op_q == CMD_DIV) ? (cnt_q == 6'd32) : (exp_q == 32'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= CMD_ADD;
		end else if (cmd.load) begin
			op_q <= in_command;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q     <= in_a;
			b_q     <= in_b;
			cnt_q   <= 6'd0;
			rem_q   <= 32'd0;
			quo_q   <= abs_a;
			dvs_q   <= abs_b;
			qneg_q  <= in_a[31] ^ in_b[31];
			acc_q   <= 32'd1;
			bas_q   <= in_a;
			exp_q   <= in_b;
			phase_q <= 1'b0;
			bad_q   <= (is_div && (in_b == 32'd0 ||
				(in_b == 32'hFFFF_FFFF && in_a == 32'h8000_0000))) ||
				(is_pow && (in_a == 32'd0 || in_b[31]));
		end else if (cmd.step) begin
			if (op_q == CMD_DIV) begin
				cnt_q <= cnt_q + 6'd1;
				if (!rem_sub[32]) begin
					rem_q <= rem_sub[31:0];
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= rem_sh[31:0];
					quo_q <= {quo_q[30:0], 1'b0};
				end
			end else if (!phase_q) begin
				if (exp_q[0]) acc_q <= mul_p;
				phase_q <= 1'b1;
			end else begin
				bas_q   <= mul_p;
				exp_q   <= {1'b0, exp_q[31:1]};
				phase_q <= 1'b0;
			end
		end
	end

	// Result selection into the output register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_status <= 1'b0;
			case (op_q)
				CMD_ADD:  res_value <= a_q + b_q;
				CMD_SUB:  res_value <= a_q - b_q;
				CMD_MUL:  res_value <= mul_p;
				CMD_DIV: begin
					res_status <= bad_q;
					res_value  <= bad_q ? 32'd0 : (qneg_q ? 32'd0 - quo_q : quo_q);
				end
				CMD_POW:  res_value <= bad_q ? 32'd0 : acc_q;
				CMD_NEG:  res_value <= 32'd0 - a_q;
				CMD_ABS:  res_value <= a_q[31] ? 32'd0 - a_q : a_q;
				CMD_PLUS: res_value <= a_q;
				CMD_EQ:   res_value <= {31'd0, a_q == b_q};
				CMD_NE:   res_value <= {31'd0, a_q != b_q};
				CMD_LT:   res_value <= {31'd0, $signed(a_q) <  $signed(b_q)};
				CMD_LE:   res_value <= {31'd0, $signed(a_q) <= $signed(b_q)};
				CMD_GT:   res_value <= {31'd0, $signed(a_q) >  $signed(b_q)};
				CMD_GE:   res_value <= {31'd0, $signed(a_q) >= $signed(b_q)};
				default:  res_value <= 32'd0;
			endcase
		end
	end
endmodule

// ===== rtl/i32alu_ctrl.sv =====
// Controller: sequences load, iteration and result hand-off.
`timescale 1ns / 1ps
module i32alu_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	output i32alu_pkg::dp_cmd_t   cmd,
	input  i32alu_pkg::dp_stat_t  stat
);
	import i32alu_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DISP = 2'd1;
	localparam logic [1:0] ST_ITER = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0] state_q;
	logic       out_valid_q;

	// Accept while idle; output register may still hold a result
	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign cmd.load   = in_valid && in_ready;
	assign cmd.step   = (state_q == ST_ITER) && !stat.iter_done;
	assign cmd.finish = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (cmd.load) state_q <= ST_DISP;
				ST_DISP: state_q <= stat.iter_op ? ST_ITER : ST_FIN;
				ST_ITER: if (stat.iter_done) state_q <= ST_FIN;
				ST_FIN:  if (cmd.finish) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/int32_expression_alu_unit.sv =====
// Top level of the 32-bit integer expression ALU.
//
//  channel | direction | tdata (low bit up)                        | tuser/tlast
//  s_axis  | in        | command[3:0], operand_a[35:4], b[67:36]  | none
//  m_axis  | out       | value[31:0], status[32], zero pad to 40  | none
//
// Simple ops go from accept via dispatch to the finish state; a new request is
// taken only back in idle. Divide runs 32 shift-subtract steps; power runs one
// multiply and one square per exponent bit up to its top set bit, on the shared
// multiplier. Divide errors, zero base and negative exponent skip the loop.
// Reset clears the controller and the output valid flag.
// A stalled result is held in the output register; a new request is taken
// meanwhile and waits in the last stage until the register frees.
`timescale 1ns / 1ps
module int32_expression_alu_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // command, operand_a, operand_b, pad
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata   // value, status, pad
);
	import i32alu_pkg::*;

	dp_cmd_t    cmd;
	dp_stat_t   stat;
	logic [31:0] res_value;
	logic        res_status;

	i32alu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.stat      (stat)
	);

	i32alu_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_command (s_axis_tdata[3:0]),
		.in_a       (s_axis_tdata[35:4]),
		.in_b       (s_axis_tdata[67:36]),
		.res_value  (res_value),
		.res_status (res_status)
	);

	assign m_axis_tdata = {7'd0, res_status, res_value};
endmodule

// ===== tb/int32_expression_alu_unit_test.sv =====
// Self-checking testbench for the 32-bit integer expression ALU stream unit.
`timescale 1ns / 1ps
module int32_expression_alu_unit_test;
	import i32alu_pkg::*;

	localparam int StallLimit = 20000;
	localparam int MaxShown   = 10;

	typedef struct packed {
		logic [31:0] value;
		logic        status;
	} alu_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata;   // command[3:0], operand_a[35:4], operand_b[67:36], pad
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;   // value[31:0], status[32], pad

	int send_idle_pct;
	int recv_stall_pct;
	alu_result_t expected_results[$];
	int mismatches = 0;
	int results_seen = 0;
	int requests_sent;
	int quiet_cycles = 0;

	int32_expression_alu_unit dut (.*);

	// Clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Square-and-multiply power with wrapping products
	function automatic logic [31:0] wrapped_power(logic signed [31:0] base,
		logic signed [31:0] ex);
		logic [31:0] acc;
		logic [31:0] sq;
		logic [31:0] e;
		acc = 32'd1;
		sq = base;
		e = ex;
		if (base == 0 || ex < 0)
			return 32'd0;
		while (e != 0) begin
			if (e[0])
				acc = acc * sq;
			e = e >> 1;
			sq = sq * sq;
		end
		return acc;
	endfunction

	// Expected value and status for one request
	function automatic alu_result_t alu_predict(logic [3:0] cmd, logic signed [31:0] a,
		logic signed [31:0] b);
		alu_result_t r;
		r = '0;
		case (cmd)
			CMD_ADD:  r.value = a + b;
			CMD_SUB:  r.value = a - b;
			CMD_MUL:  r.value = a * b;
			CMD_DIV: begin
				if (b == 0 || (b == -1 && a == 32'sh8000_0000))
					r.status = 1'b1;
				else
					r.value = a / b;
			end
			CMD_POW:  r.value = wrapped_power(a, b);
			CMD_NEG:  r.value = -a;
			CMD_ABS:  r.value = (a < 0) ? -a : a;
			CMD_PLUS: r.value = a;
			CMD_EQ:   r.value = {31'd0, a == b};
			CMD_NE:   r.value = {31'd0, a != b};
			CMD_LT:   r.value = {31'd0, a < b};
			CMD_LE:   r.value = {31'd0, a <= b};
			CMD_GT:   r.value = {31'd0, a > b};
			CMD_GE:   r.value = {31'd0, a >= b};
			default:  r = '0;
		endcase
		return r;
	endfunction

	// Send one request, with optional idle gap before it
	task automatic send_request(logic [3:0] cmd, logic [31:0] a, logic [31:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'd0, b, a, cmd};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		expected_results.push_back(alu_predict(cmd, a, b));
		requests_sent++;
	endtask

	// Receiver stalls and result checking
	always @(posedge clk) begin
		alu_result_t got;
		alu_result_t want;
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.value = m_axis_tdata[31:0];
			got.status = m_axis_tdata[32];
			results_seen++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MaxShown)
					$display("result with no request pending: value %h status %b",
						got.value, got.status);
			end else begin
				want = expected_results.pop_front();
				if (got.value !== want.value || got.status !== want.status) begin
					mismatches++;
					if (mismatches <= MaxShown)
						$display("mismatch: expected value %h status %b, got %h %b",
							want.value, want.status, got.value, got.status);
				end
			end
		end
	end

	// Watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > StallLimit) begin
			$display("** int32_expression_alu_unit: FAILED **");
			$finish;
		end
	end

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(5))
			0: return 32'h8000_0000 + $urandom_range(3) - 1;
			1: return $urandom_range(8) - 4;
			2: return {$urandom_range(1) ? 24'hFFFFFF : 24'h0, 8'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	task automatic test_directed();
		logic [31:0] edges[6];
		edges = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd7};
		foreach (edges[i])
			send_request(CMD_PLUS, edges[i], ~edges[i]);
		send_request(CMD_DIV, 32'd5, 32'd0);
		send_request(CMD_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
		send_request(CMD_DIV, -32'sd7, 32'd2);
		send_request(CMD_POW, 32'd0, 32'd0);
		send_request(CMD_POW, 32'd3, 32'hFFFF_FFFF);
		send_request(CMD_POW, 32'd3, 32'h7FFF_FFFF);
		send_request(CMD_NEG, 32'h8000_0000, 32'd0);
		send_request(CMD_ABS, 32'h8000_0000, 32'd0);
		for (int c = 0; c < 16; c++)
			if (c != CMD_PLUS)
				send_request(4'(c), 32'h7FFF_FFFF, 32'h8000_0000);
	endtask

	task automatic test_random(int count, int idle_pct, int stall_pct);
		logic [3:0] cmd;
		logic [31:0] b;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count) begin
			cmd = 4'($urandom_range(15));
			b = pick_operand();
			// keep most exponents short so power stays quick
			if (cmd == CMD_POW && $urandom_range(3) != 0)
				b = $urandom_range(40) - 4;
			send_request(cmd, pick_operand(), b);
		end
	endtask

	initial begin
		int drain;
		bit leftover;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		requests_sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(460, 0, 0);
		test_random(460, 63, 0);
		test_random(460, 0, 63);
		test_random(460, 11, 11);
		s_axis_tvalid <= 1'b0;
		drain = 0;
		while (expected_results.size() != 0 && drain < StallLimit) begin
			@(posedge clk);
			drain++;
		end
		repeat (100) @(posedge clk);
		leftover = (expected_results.size() != 0);
		$display("Sent %0d requests over all 16 command codes, %0d results checked,",
			requests_sent, results_seen);
		$display("with sender gaps and receiver stalls in four phases; %0d mismatches.",
			mismatches);
		if (mismatches == 0 && !leftover)
			$display("** int32_expression_alu_unit: PASSED **");
		else
			$display("** int32_expression_alu_unit: FAILED **");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/i32alu_pkg.sv
rtl/i32alu_dp.sv
rtl/i32alu_ctrl.sv
rtl/int32_expression_alu_unit.sv
tb/int32_expression_alu_unit_test.sv
